[rtl/core/cgpd_pkg.sv]
// cgpd_pkg: widths, register indexes and reset values of the column group peak decimator
// no dependencies; used by the channel interfaces, the core and its checker

package cgpd_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int BIN_W      = 10;
    localparam int PCOL_W     = 16;
    localparam int CPP_W      = 9;
    localparam int HEIGHT_W   = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CPP_W-1:0]    CPP_RESET    = 9'd1;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 11'd1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLUMNS_PER_PEAK = 2'd0,
        CFG_COLUMN_HEIGHT    = 2'd1
    } t_cfg_idx;

endpackage

[rtl/core/cgpd_if.sv]
// cgpd channel interfaces: sample input, peak result output and register write
// depends on cgpd_pkg for field widths

interface cgpd_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [cgpd_pkg::SAMPLE_W-1:0]   sample;
    logic                                   final_column;

    modport source (output valid, output sample, output final_column, input ready);
    modport sink   (input valid, input sample, input final_column, output ready);
endinterface

interface cgpd_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [cgpd_pkg::SAMPLE_W-1:0]   peak;
    logic        [cgpd_pkg::BIN_W-1:0]      bin;
    logic        [cgpd_pkg::PCOL_W-1:0]     peak_column;
    logic                                   end_of_peak;
    logic                                   incomplete;

    modport source (output valid, output peak, output bin, output peak_column,
                    output end_of_peak, output incomplete, input ready);
    modport sink   (input valid, input peak, input bin, input peak_column,
                    input end_of_peak, input incomplete, output ready);
endinterface

interface cgpd_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [cgpd_pkg::CFG_IDX_W-1:0]         index;
    logic [cgpd_pkg::CFG_DATA_W-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/column_group_peak_decimator_core.sv]
// column_group_peak_decimator_core: per-bin max pooling over groups of grid columns
// depends on cgpd_pkg and the channel interfaces in cgpd_if.sv

// Takes a dense grid one bin sample per transaction, column after column, and
// merges every columns_per_peak source columns into one peak column. The first
// column of a group writes the peak store, later columns keep the signed larger
// value per bin, and while the last column of a group streams in, each bin's
// maximum leaves with its bin index, peak column index and end-of-column flag.
// A bin marked final_column closes the group early (flagged incomplete when the
// group was short) and restarts peak column numbering at zero. The block takes
// one transaction per cycle while the input is not stalled. For each transaction,
// the accepting edge registers the sample and reads the peak store (one read
// and one write port, with a bypass for a bin touched by the item just ahead),
// and when the compare stage moves on it compares, writes back and loads the
// result register. Outside reset, the input stalls only when a result waits
// unaccepted in the result register and a second one is ready behind it. The
// store needs no clearing after reset: the first column of a group always
// writes before any compare. Register writes take effect at once and restart
// the column and group count; issue them only while the block is idle.

module column_group_peak_decimator_core #(
    parameter int MAX_BINS  = 1024,
    parameter int MAX_GROUP = 256
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    cgpd_in_if.sink    i_in,
    cgpd_out_if.source o_out,
    cgpd_cfg_if.sink   i_cfg
);

    // address and count widths follow from the store depth and the group limit
    localparam int AW   = (MAX_BINS > 2) ? $clog2(MAX_BINS) : 1;
    localparam int HW   = $clog2(MAX_BINS + 1);
    localparam int CW   = (HW > cgpd_pkg::HEIGHT_W) ? HW : cgpd_pkg::HEIGHT_W;
    localparam int GW   = (MAX_GROUP > 2) ? $clog2(MAX_GROUP) : 1;
    localparam int GHW  = $clog2(MAX_GROUP + 1);
    localparam int GEW  = (GHW > cgpd_pkg::CPP_W) ? GHW : cgpd_pkg::CPP_W;
    localparam int SW   = cgpd_pkg::SAMPLE_W;

    // configuration registers
    logic [cgpd_pkg::CPP_W-1:0]    r_cpp;
    logic [cgpd_pkg::HEIGHT_W-1:0] r_height;

    // position counters
    logic [AW-1:0]               r_bin_count, n_bin_count;
    logic [GW-1:0]               r_cig, n_cig;
    logic [cgpd_pkg::PCOL_W-1:0] r_pcc, n_pcc;

    // peak store, contents undefined until written
    logic [SW-1:0] r_store [MAX_BINS];

    // compare stage
    logic                        r_s1_valid;
    logic [SW-1:0]               r_s1_sample;
    logic [AW-1:0]               r_s1_addr;
    logic                        r_s1_first;
    logic                        r_s1_emit;
    logic                        r_s1_last_bin;
    logic                        r_s1_incomplete;
    logic [cgpd_pkg::PCOL_W-1:0] r_s1_pcol;
    logic [SW-1:0]               r_rd_data;
    logic                        r_fwd;
    logic [SW-1:0]               r_fwd_data;

    // result register
    logic                        r_out_valid;
    logic [SW-1:0]               r_out_peak;
    logic [cgpd_pkg::BIN_W-1:0]  r_out_bin;
    logic [cgpd_pkg::PCOL_W-1:0] r_out_pcol;
    logic                        r_out_eop;
    logic                        r_out_incomplete;

    logic          cfg_wr;
    logic          cfg_hit;
    logic [CW-1:0] h_ext, h_eff;
    logic [GEW-1:0] g_ext, g_eff;
    logic [AW-1:0] b;
    logic          last_bin;
    logic          last_of_group;
    logic          in_acc;
    logic          in_ready;
    logic          s1_adv;
    logic [SW-1:0] old_peak;
    logic [SW-1:0] new_peak;

    // ---------------------------------------------------------------
    // configuration port, always ready outside reset
    // ---------------------------------------------------------------
    assign i_cfg.ready = i_rst_n;
    assign cfg_wr      = i_cfg.valid && i_rst_n;

    always_comb begin
        cfg_hit = 1'b0;
        unique case (i_cfg.index)
            cgpd_pkg::CFG_COLUMNS_PER_PEAK: cfg_hit = cfg_wr;
            cgpd_pkg::CFG_COLUMN_HEIGHT:    cfg_hit = cfg_wr;
            default:                        cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpp    <= cgpd_pkg::CPP_RESET;
            r_height <= cgpd_pkg::HEIGHT_RESET;
        end else if (cfg_wr) begin
            unique case (i_cfg.index)
                cgpd_pkg::CFG_COLUMNS_PER_PEAK: r_cpp    <= i_cfg.data[cgpd_pkg::CPP_W-1:0];
                cgpd_pkg::CFG_COLUMN_HEIGHT:    r_height <= i_cfg.data[cgpd_pkg::HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // effective height and group size, clamped into their legal ranges
    // ---------------------------------------------------------------
    assign h_ext = CW'(r_height);
    assign g_ext = GEW'(r_cpp);

    always_comb begin
        if (h_ext == '0) begin
            h_eff = CW'(1);
        end else if (h_ext > CW'(MAX_BINS)) begin
            h_eff = CW'(MAX_BINS);
        end else begin
            h_eff = h_ext;
        end
        if (g_ext == '0) begin
            g_eff = GEW'(1);
        end else if (g_ext > GEW'(MAX_GROUP)) begin
            g_eff = GEW'(MAX_GROUP);
        end else begin
            g_eff = g_ext;
        end
    end

    // ---------------------------------------------------------------
    // input side: bin position and group flags of the arriving sample
    // ---------------------------------------------------------------
    assign b             = (CW'(r_bin_count) >= h_eff) ? '0 : r_bin_count;
    assign last_bin      = (CW'(b) + CW'(1)) == h_eff;
    assign last_of_group = (GEW'(r_cig) + GEW'(1)) >= g_eff;

    // the compare stage moves on when it has no result or the result register frees up
    assign s1_adv   = r_s1_valid && (!r_s1_emit || !r_out_valid || o_out.ready);
    assign in_ready = i_rst_n && (!r_s1_valid || s1_adv);
    assign in_acc   = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    always_comb begin
        n_bin_count = r_bin_count;
        n_cig       = r_cig;
        n_pcc       = r_pcc;
        if (cfg_hit) begin
            // register write restarts the column and the group
            n_bin_count = '0;
            n_cig       = '0;
        end else if (in_acc) begin
            if (last_bin) begin
                n_bin_count = '0;
                if (i_in.final_column) begin
                    // source end: next source starts at peak column zero
                    n_cig = '0;
                    n_pcc = '0;
                end else if (last_of_group) begin
                    n_cig = '0;
                    n_pcc = r_pcc + 1'b1;
                end else begin
                    n_cig = r_cig + 1'b1;
                end
            end else begin
                n_bin_count = b + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_count <= '0;
            r_cig       <= '0;
            r_pcc       <= '0;
        end else begin
            r_bin_count <= n_bin_count;
            r_cig       <= n_cig;
            r_pcc       <= n_pcc;
        end
    end

    // ---------------------------------------------------------------
    // peak store: read on accept, write back when the compare stage moves on
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_store[r_s1_addr] <= new_peak;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd_data  <= r_store[b];
            // same bin written at this edge: the read above sees the old word
            r_fwd      <= s1_adv && (r_s1_addr == b);
            r_fwd_data <= new_peak;
        end
    end

    // ---------------------------------------------------------------
    // compare stage
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_sample     <= i_in.sample;
            r_s1_addr       <= b;
            r_s1_first      <= (r_cig == '0);
            r_s1_emit       <= last_of_group || i_in.final_column;
            r_s1_last_bin   <= last_bin;
            r_s1_incomplete <= i_in.final_column && !last_of_group;
            r_s1_pcol       <= r_pcc;
        end
    end

    assign old_peak = r_fwd ? r_fwd_data : r_rd_data;

    always_comb begin
        if (r_s1_first || ($signed(r_s1_sample) > $signed(old_peak))) begin
            new_peak = r_s1_sample;
        end else begin
            new_peak = old_peak;
        end
    end

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && r_s1_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_emit) begin
            r_out_peak       <= new_peak;
            r_out_bin        <= cgpd_pkg::BIN_W'(r_s1_addr);
            r_out_pcol       <= r_s1_pcol;
            r_out_eop        <= r_s1_last_bin;
            r_out_incomplete <= r_s1_incomplete;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.peak        = r_out_peak;
    assign o_out.bin         = r_out_bin;
    assign o_out.peak_column = r_out_pcol;
    assign o_out.end_of_peak = r_out_eop;
    assign o_out.incomplete  = r_out_incomplete;

endmodule

[rtl/core/cgpd_checker.sv]
// cgpd_checker: port-level assertions for column_group_peak_decimator_core
// depends on cgpd_pkg; bound to the core by the bind statement at the end

module cgpd_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 i_in_ready,
    input logic                                 i_out_valid,
    input logic                                 i_out_ready,
    input logic [cgpd_pkg::SAMPLE_W-1:0]        i_out_peak,
    input logic [cgpd_pkg::BIN_W-1:0]           i_out_bin,
    input logic [cgpd_pkg::PCOL_W-1:0]          i_out_pcol,
    input logic                                 i_cfg_ready
);

    // a result waiting on the sink keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_peak) && $stable(i_out_bin) && $stable(i_out_pcol)))
        else $error("result payload changed while stalled");

    // reset empties the result register
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a fresh result must trace back to an earlier input transaction
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("result without a matching input transaction");

    // no transaction on either write-side channel is taken during reset
    a_reset_not_ready: assert property (@(posedge i_clk)
        !i_rst_n |-> (!i_in_ready && !i_cfg_ready))
        else $error("ready high during reset");

endmodule

bind column_group_peak_decimator_core cgpd_checker u_cgpd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_peak  (o_out.peak),
    .i_out_bin   (o_out.bin),
    .i_out_pcol  (o_out.peak_column),
    .i_cfg_ready (i_cfg.ready)
);
